// ===== rtl/sam_pkg.sv =====
// Shared constants, codes and control types of the section allocation map.
package sam_pkg;

  localparam int MAX_SECTIONS_DEF = 512;
  localparam int WORD_W           = 32;
  localparam int BIT_W            = 5;
  localparam int SEC_W            = 9;
  localparam int OP_W             = 2;
  localparam int STAT_W           = 3;
  localparam int ADDR_W           = 32;
  localparam int SECTION_SHIFT    = 20;

  localparam logic [ADDR_W-1:0] MACHINE_LIMIT = 32'h2000_0000;
  localparam logic [SEC_W-1:0]  CFG_RESET     = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC_ANY   = 2'd0,
    OP_ALLOC_EXACT = 2'd1,
    OP_FREE        = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_TAKEN     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_ALLOC = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic load_req;
    logic rd_en;
    logic set_early;
    logic commit;
    logic next_row;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic early;
    logic hit;
    logic is_any;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sam_if.sv =====
// Request and response channel interfaces of the section allocation map.
interface sam_req_if import sam_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               op;
  logic [SEC_W-1:0]  section_index;
  logic [ADDR_W-1:0] phys_address;

  modport source (output valid, op, section_index, phys_address, input ready);
  modport sink   (input valid, op, section_index, phys_address, output ready);
endinterface

interface sam_rsp_if import sam_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [SEC_W-1:0] granted_section;
  logic             is_allocated;

  modport source (output valid, status, granted_section, is_allocated, input ready);
  modport sink   (input valid, status, granted_section, is_allocated, output ready);
endinterface

// ===== rtl/sam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sam_ctrl.sv =====
// Request sequencer: accept, look up, check and deliver one word at a time.
module sam_ctrl import sam_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sts.req_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = sts.early ? S_DONE : S_CHECK;
      end
      S_CHECK: begin
        state_next = (sts.is_any && !sts.hit) ? S_LOOKUP : S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.idle     = 1'b1;
        cmd.load_req = sts.req_valid;
      end
      S_LOOKUP: begin
        cmd.rd_en     = !sts.early;
        cmd.set_early = sts.early;
      end
      S_CHECK: begin
        cmd.commit   = !sts.is_any || sts.hit;
        cmd.next_row = sts.is_any && !sts.hit;
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/sam_dp.sv =====
// Map storage, request registers, bit search and response register.
module sam_dp import sam_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int ROWS         = (MAX_SECTIONS + WORD_W - 1) / WORD_W,
  parameter int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SEC_W-1:0]  cfg_wr_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              req_valid,
  input  op_t               req_op_in,
  input  logic [SEC_W-1:0]  req_section_index,
  input  logic [ADDR_W-1:0] req_phys_address,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output status_t           rsp_status,
  output logic [SEC_W-1:0]  rsp_granted_section,
  output logic              rsp_is_allocated
);

  localparam int CMP_RAW = $clog2(MAX_SECTIONS + WORD_W) + 1;
  localparam int CMP_W   = (CMP_RAW > SEC_W + 1) ? CMP_RAW : SEC_W + 1;
  localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_SECTIONS);

  logic [SEC_W-1:0]  sections_in_use;
  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  lim;

  op_t               req_op;
  logic [SEC_W-1:0]  req_sec;
  logic              req_machine;
  logic [ROW_W:0]    scan_row;

  logic [CMP_W-1:0]  base;
  logic [CMP_W-1:0]  sec_ext;
  logic [CMP_W-1:0]  remaining;
  logic [ROW_W-1:0]  sec_row;
  logic [ROW_W-1:0]  rd_row;

  logic [ROWS-1:0]   row_valid;
  logic              rd_valid;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] word;

  logic [WORD_W-1:0] avail;
  logic [BIT_W-1:0]  free_idx;
  logic              hit;
  logic [BIT_W-1:0]  bit_pos;
  logic              cur_bit;
  logic [WORD_W-1:0] pos_mask;
  logic [WORD_W-1:0] wr_data;
  logic              wr_cond;
  logic              wr_en;
  logic              early;

  status_t           st_status;
  logic [SEC_W-1:0]  st_granted;
  logic              st_alloc;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sections_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      sections_in_use <= cfg_wr_data;
    end
  end

  assign cfg_ext = CMP_W'(sections_in_use);
  assign lim     = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op      <= req_op_in;
      req_sec     <= (req_op_in == OP_QUERY) ? req_phys_address[SECTION_SHIFT +: SEC_W]
                                             : req_section_index;
      req_machine <= (req_phys_address >= MACHINE_LIMIT);
      scan_row    <= '0;
    end else if (cmd.next_row) begin
      scan_row    <= scan_row + 1'b1;
    end
  end

  assign base      = CMP_W'({scan_row, {BIT_W{1'b0}}});
  assign sec_ext   = CMP_W'(req_sec);
  assign remaining = lim - base;
  assign sec_row   = ROW_W'(req_sec >> BIT_W);
  assign rd_row    = (req_op == OP_ALLOC_ANY) ? scan_row[ROW_W-1:0] : sec_row;

  always_comb begin
    case (req_op)
      OP_ALLOC_ANY:   early = (base >= lim);
      OP_ALLOC_EXACT: early = (sec_ext >= lim);
      OP_FREE:        early = (sec_ext >= lim);
      OP_QUERY:       early = req_machine || (sec_ext >= lim);
      default:        early = 1'b1;
    endcase
  end

  sam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_row),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_row),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[rd_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid <= row_valid[rd_row];
    end
  end

  assign word = rd_valid ? rd_data : '0;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      avail[b] = !word[b] && (remaining > CMP_W'(b));
    end
  end

  always_comb begin
    free_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) free_idx = BIT_W'(b);
    end
  end

  assign hit      = |avail;
  assign bit_pos  = req_sec[BIT_W-1:0];
  assign cur_bit  = word[bit_pos];
  assign pos_mask = WORD_W'(1) << bit_pos;

  always_comb begin
    wr_cond = 1'b0;
    wr_data = word;
    case (req_op)
      OP_ALLOC_ANY: begin
        wr_cond = 1'b1;
        wr_data = word | (WORD_W'(1) << free_idx);
      end
      OP_ALLOC_EXACT: begin
        wr_cond = !cur_bit;
        wr_data = word | pos_mask;
      end
      OP_FREE: begin
        wr_cond = cur_bit;
        wr_data = word & ~pos_mask;
      end
      default: begin
        wr_cond = 1'b0;
        wr_data = word;
      end
    endcase
  end

  assign wr_en = cmd.commit && wr_cond;

  always_ff @(posedge clk) begin
    if (cmd.set_early) begin
      st_granted <= '0;
      if (req_op == OP_ALLOC_ANY) begin
        st_status <= STAT_FULL;
        st_alloc  <= 1'b0;
      end else if (req_op == OP_QUERY && req_machine) begin
        st_status <= STAT_OK;
        st_alloc  <= 1'b1;
      end else begin
        st_status <= STAT_RANGE;
        st_alloc  <= 1'b0;
      end
    end else if (cmd.commit) begin
      case (req_op)
        OP_ALLOC_ANY: begin
          st_status  <= STAT_OK;
          st_granted <= SEC_W'(base + CMP_W'(free_idx));
          st_alloc   <= 1'b0;
        end
        OP_ALLOC_EXACT: begin
          st_status  <= cur_bit ? STAT_TAKEN : STAT_OK;
          st_granted <= '0;
          st_alloc   <= 1'b0;
        end
        OP_FREE: begin
          st_status  <= cur_bit ? STAT_OK : STAT_NOT_ALLOC;
          st_granted <= '0;
          st_alloc   <= 1'b0;
        end
        default: begin
          st_status  <= STAT_OK;
          st_granted <= '0;
          st_alloc   <= cur_bit;
        end
      endcase
    end
  end

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_status          <= st_status;
      rsp_granted_section <= st_granted;
      rsp_is_allocated    <= st_alloc;
    end
  end

  assign sts.req_valid = req_valid;
  assign sts.early     = early;
  assign sts.hit       = hit;
  assign sts.is_any    = (req_op == OP_ALLOC_ANY);
  assign sts.out_free  = out_free;

endmodule

// ===== rtl/section_allocation_map.sv =====
// Top level of the section allocation map: 1 MB section bitmap allocator.
// Usage:
//   req carries one word per request: op, section_index, phys_address.
//   rsp returns one word per request: status, granted_section, is_allocated.
//   cfg_wr_en/cfg_wr_data write sections_in_use; write only while idle.
// Sequencing:
//   Allocate exact, free and query pass through the lookup, check and done states
//   from acceptance to rsp.valid. Allocate any reads the map one 32-section row per
//   lookup and check pass until it finds a free section or reaches the limit.
//   An out-of-range section or a machine-owned address answers without a map
//   read, going from lookup straight to done.
//   One request is in flight at a time; req.ready returns as the result moves
//   into the output register, together with rsp.valid.
// Reset:
//   Clears the map through per-row valid bits, with no clearing pass, and
//   sets sections_in_use to 256.
// Stall:
//   A held result sits in the output register; the next request may be
//   accepted and worked on, and waits at its end for the register to free.
module section_allocation_map import sam_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sam_req_if.sink          req,
  sam_rsp_if.source        rsp,
  input  logic             cfg_wr_en,
  input  logic [SEC_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  sam_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sam_dp #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_valid           (req.valid),
    .req_op_in           (req.op),
    .req_section_index   (req.section_index),
    .req_phys_address    (req.phys_address),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_granted_section (rsp.granted_section),
    .rsp_is_allocated    (rsp.is_allocated)
  );

  assign req.ready = cmd.idle;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.granted_section != '0) |-> rsp.status == STAT_OK)
    else $error("nonzero grant with failing status");

  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.is_allocated |-> rsp.status == STAT_OK)
    else $error("allocated answer with failing status");

endmodule

// ===== tb/sv/sam_checker.sv =====
`timescale 1ns / 100ps
// Checker for the section allocation map: predicts each answer and compares it with the response.
module sam_checker import sam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  sam_req_if               req,
  sam_rsp_if               rsp,
  input  logic             cfg_wr_en,
  input  logic [SEC_W-1:0] cfg_wr_data,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    status_t          status;
    logic [SEC_W-1:0] granted;
    logic             alloc;
  } answer_t;

  logic             section_used [MAX_SECTIONS_DEF];
  logic [SEC_W-1:0] sections_in_use;
  answer_t          expected_answers [$];
  int               mismatches;

  function automatic int unsigned legal_limit();
    int unsigned lim;
    lim = sections_in_use;
    if (lim > MAX_SECTIONS_DEF) lim = MAX_SECTIONS_DEF;
    return lim;
  endfunction

  function automatic answer_t resolve_request(op_t o, logic [SEC_W-1:0] s,
                                              logic [ADDR_W-1:0] a);
    answer_t     ans;
    int unsigned lim;
    int unsigned q;
    logic        found;
    lim   = legal_limit();
    ans   = '{status: STAT_OK, granted: '0, alloc: 1'b0};
    found = 1'b0;
    case (o)
      OP_ALLOC_ANY: begin
        ans.status = STAT_FULL;
        for (int i = 0; i < lim; i++) begin
          if (!found && !section_used[i]) begin
            found = 1'b1;
            section_used[i] = 1'b1;
            ans.granted = SEC_W'(i);
            ans.status = STAT_OK;
          end
        end
      end
      OP_ALLOC_EXACT: begin
        if (s >= lim) ans.status = STAT_RANGE;
        else if (section_used[s]) ans.status = STAT_TAKEN;
        else section_used[s] = 1'b1;
      end
      OP_FREE: begin
        if (s >= lim) ans.status = STAT_RANGE;
        else if (!section_used[s]) ans.status = STAT_NOT_ALLOC;
        else section_used[s] = 1'b0;
      end
      default: begin
        if (a >= MACHINE_LIMIT) begin
          ans.alloc = 1'b1;
        end else begin
          q = a >> SECTION_SHIFT;
          if (q >= lim) ans.status = STAT_RANGE;
          else ans.alloc = section_used[q];
        end
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < MAX_SECTIONS_DEF; i++) section_used[i] = 1'b0;
      sections_in_use = CFG_RESET;
      expected_answers.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) sections_in_use = cfg_wr_data;
      if (req.valid && req.ready)
        expected_answers.push_back(resolve_request(req.op, req.section_index,
                                                   req.phys_address));
      if (rsp.valid && rsp.ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word status=%0d granted=%0d alloc=%0d", $time,
                     rsp.status, rsp.granted_section, rsp.is_allocated);
        end else begin
          want = expected_answers.pop_front();
          if (rsp.status !== want.status || rsp.granted_section !== want.granted ||
              rsp.is_allocated !== want.alloc) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp status=%0d granted=%0d alloc=%0d, got %0d %0d %0d",
                       $time, want.status, want.granted, want.alloc,
                       rsp.status, rsp.granted_section, rsp.is_allocated);
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= expected_answers.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the section allocation map: stimulus, response stalls and verdict.
module tb;
  import sam_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 40;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [SEC_W-1:0] cfg_wr_data;
  int               errors;
  int               pending;
  int               idle_cycles;
  logic             hold_off_pending;

  sam_req_if req ();
  sam_rsp_if rsp ();

  section_allocation_map dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sam_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_word(op_t o, logic [SEC_W-1:0] s, logic [ADDR_W-1:0] a);
    @(negedge clk);
    req.valid         <= 1'b1;
    req.op            <= o;
    req.section_index <= s;
    req.phys_address  <= a;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic hold_requests(int n);
    repeat (n) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  task automatic drain();
    hold_requests(1);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [SEC_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(int unsigned limit, int unsigned count, int unsigned alloc_pct);
    op_t              o;
    logic [SEC_W-1:0] s;
    logic [ADDR_W-1:0] a;
    int unsigned      n;
    int unsigned      burst;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 20) o = OP_QUERY;
        else if ($urandom_range(0, 99) < alloc_pct)
          o = $urandom_range(0, 1) ? OP_ALLOC_ANY : OP_ALLOC_EXACT;
        else o = OP_FREE;
        if ($urandom_range(0, 9) == 0) s = SEC_W'($urandom_range(0, 511));
        else s = SEC_W'($urandom_range(0, limit - 1));
        case ($urandom_range(0, 5))
          0:       a = $urandom();
          1:       a = MACHINE_LIMIT - ADDR_W'($urandom_range(0, 1));
          2:       a = {3'b000, 9'($urandom_range(0, 511)), 20'($urandom())};
          default: a = {3'b000, 9'($urandom_range(0, limit - 1)), 20'($urandom())};
        endcase
        send_word(o, s, a);
        n++;
      end
      if ($urandom_range(0, 3) != 0) hold_requests($urandom_range(1, 10));
    end
  endtask

  initial begin
    int unsigned      mode;
    int unsigned      mode_left;
    int unsigned      hold_left;
    int unsigned      phase_cnt;
    rsp.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= $urandom_range(0, 1);
          2:       rsp.ready <= (phase_cnt % 4 == 0);
          default: rsp.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL section_allocation_map");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    hold_off_pending  = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = CFG_RESET;
    req.valid         = 1'b0;
    req.op            = OP_QUERY;
    req.section_index = '0;
    req.phys_address  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit: last legal section and first illegal one
    send_word(OP_QUERY, '0, 32'h0FFF_FFFF);
    send_word(OP_QUERY, '0, 32'h1000_0000);
    drain();

    write_limit(9'd2);
    send_word(OP_ALLOC_ANY, '0, '0);
    send_word(OP_ALLOC_ANY, '0, '0);
    send_word(OP_ALLOC_ANY, '0, '0);
    send_word(OP_ALLOC_EXACT, 9'd1, '0);
    send_word(OP_ALLOC_EXACT, 9'd511, '0);
    send_word(OP_FREE, 9'd0, '0);
    send_word(OP_FREE, 9'd0, '0);
    send_word(OP_FREE, 9'd2, '0);
    send_word(OP_QUERY, '0, 32'h0000_0000);
    send_word(OP_QUERY, '0, 32'h0010_0000);
    send_word(OP_QUERY, '0, 32'h1FFF_FFFF);
    send_word(OP_QUERY, '0, 32'h2000_0000);
    send_word(OP_QUERY, '0, 32'hFFFF_FFFF);
    drain();

    // lowered limit keeps section one but hides it
    write_limit(9'd1);
    send_word(OP_ALLOC_ANY, '0, '0);
    send_word(OP_ALLOC_ANY, '0, '0);
    send_word(OP_QUERY, '0, 32'h0010_0000);
    send_word(OP_FREE, 9'd1, '0);
    drain();

    write_limit(9'd511);
    send_word(OP_QUERY, '0, 32'h001F_FFFF);
    send_word(OP_ALLOC_EXACT, 9'd510, '0);
    send_word(OP_QUERY, '0, 32'h1FEF_FFFF);
    send_word(OP_FREE, 9'd510, '0);
    send_word(OP_ALLOC_ANY, '0, '0);
    drain();

    write_limit(9'd40);
    hold_off_pending = 1'b1;
    random_phase(40, 150, 70);
    drain();
    random_phase(40, 100, 20);
    drain();
    write_limit(9'd511);
    random_phase(511, 150, 60);
    drain();
    write_limit(9'd3);
    random_phase(3, 80, 60);
    drain();
    write_limit(9'd200);
    random_phase(200, 120, 50);
    drain();
    write_limit(9'd17);
    random_phase(17, 100, 75);
    drain();
    write_limit(9'd1);
    random_phase(1, 40, 50);
    drain();
    write_limit(9'd511);
    random_phase(511, 150, 40);
    drain();

    if (errors == 0) begin
      $display("PASS section_allocation_map");
    end else begin
      $display("FAIL section_allocation_map");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sam_pkg.sv
rtl/sam_if.sv
rtl/sam_ram.sv
rtl/sam_ctrl.sv
rtl/sam_dp.sv
rtl/section_allocation_map.sv
tb/sv/sam_checker.sv
tb/sv/tb.sv
